// ===== rtl/htlfc_pkg.sv =====
package htlfc_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [BYTE_W-1:0] HEAD_RESET = 8'hFE;
  localparam logic [BYTE_W-1:0] TAIL_RESET = 8'hFF;
  localparam logic [BYTE_W-1:0] COUNT_MAX  = 8'hFF;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL = 2'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2,
    KIND_ABORT   = 2'd3
  } kind_t;

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] payload_count;
    logic [BYTE_W-1:0] declared_length;
  } res_t;

  typedef struct packed {
    logic in_frame;
  } stat_t;

endpackage

// ===== rtl/htlfc_if.sv =====
// Received byte channel.
interface htlfc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel.
interface htlfc_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] payload_byte;
  logic [7:0] payload_count;
  logic [7:0] declared_length;

  modport source (output valid, output kind, output payload_byte, output payload_count,
                  output declared_length, input ready);
  modport sink   (input valid, input kind, input payload_byte, input payload_count,
                  input declared_length, output ready);
endinterface

// Config write channel.
interface htlfc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/htlfc_core.sv =====
module htlfc_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [7:0]                rx_byte,
  input  logic [7:0]                head_value,
  input  logic [7:0]                tail_value,
  output htlfc_pkg::res_t           res,
  output htlfc_pkg::stat_t          stat
);
  import htlfc_pkg::*;

  logic              in_frame, in_frame_next;
  logic              length_seen, length_seen_next;
  logic [BYTE_W-1:0] length_byte, length_byte_next;
  logic [BYTE_W-1:0] byte_count, byte_count_next;
  logic              good;

  assign good = length_seen && (byte_count != '0) && (byte_count == length_byte);

  always_comb begin
    in_frame_next       = in_frame;
    length_seen_next    = length_seen;
    length_byte_next    = length_byte;
    byte_count_next     = byte_count;
    res.valid           = 1'b0;
    res.kind            = KIND_PAYLOAD;
    res.payload_byte    = '0;
    res.payload_count   = byte_count;
    res.declared_length = length_byte;

    if (!in_frame) begin
      if (rx_byte == head_value) begin
        in_frame_next    = 1'b1;
        length_seen_next = 1'b0;
        length_byte_next = '0;
        byte_count_next  = '0;
      end
    end else if (rx_byte == head_value) begin
      // abort reports the old frame, then restarts
      res.valid        = 1'b1;
      res.kind         = KIND_ABORT;
      length_seen_next = 1'b0;
      length_byte_next = '0;
      byte_count_next  = '0;
    end else if (rx_byte == tail_value) begin
      res.valid        = 1'b1;
      res.kind         = good ? KIND_GOOD : KIND_BAD;
      in_frame_next    = 1'b0;
      length_seen_next = 1'b0;
      length_byte_next = '0;
      byte_count_next  = '0;
    end else if (!length_seen) begin
      length_seen_next = 1'b1;
      length_byte_next = rx_byte;
    end else begin
      if (byte_count != COUNT_MAX) begin
        byte_count_next = byte_count + 8'd1;
      end
      res.valid         = 1'b1;
      res.kind          = KIND_PAYLOAD;
      res.payload_byte  = rx_byte;
      res.payload_count = byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      length_seen <= 1'b0;
      length_byte <= '0;
      byte_count  <= '0;
    end else if (step) begin
      in_frame    <= in_frame_next;
      length_seen <= length_seen_next;
      length_byte <= length_byte_next;
      byte_count  <= byte_count_next;
    end
  end

  assign stat.in_frame = in_frame;

endmodule

// ===== rtl/head_tail_length_frame_checker_unit.sv =====
// Head/tail/length frame checker.
// rx    : one raw received byte per beat (valid/ready).
// res   : zero or one result beat per received byte: kind (payload, good,
//         bad, abort), the payload byte, the running payload count
//         (saturating at 255) and the frame's length byte.
// cfg   : register writes, index 0 = head byte value, index 1 = tail byte
//         value; always ready. Write only while the block is idle.
// Frames are head, length, payload..., tail. Bytes outside a frame are
// dropped. A tail closes the frame: good when the count is nonzero and
// equals the length byte. A head inside a frame reports an abort and
// restarts the frame.
// A byte taken into the input register gives its result in the result register
// once the core steps it. Throughput: one byte per cycle while res.ready stays
// high, set by the state update between the input register and the result
// register.
// Reset clears the frame state, empties both registers and loads head = 0xFE,
// tail = 0xFF. When the receiver stalls, the result is held and the input
// register keeps one more byte; rx.ready then drops until res is taken.
module head_tail_length_frame_checker_unit (
  input logic         clk,
  input logic         rst,
  htlfc_byte_if.sink  rx,
  htlfc_res_if.source res,
  htlfc_cfg_if.sink   cfg
);
  import htlfc_pkg::*;

  logic [BYTE_W-1:0] head_value;
  logic [BYTE_W-1:0] tail_value;

  // input register
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;

  // result register
  logic              out_valid;
  kind_t             out_kind;
  logic [BYTE_W-1:0] out_payload_byte;
  logic [BYTE_W-1:0] out_payload_count;
  logic [BYTE_W-1:0] out_declared_length;

  logic    advance;
  logic    step;
  res_t    core_res;
  stat_t   core_stat;

  // result slot is free or being drained this cycle
  assign advance  = !out_valid || res.ready;
  assign step     = in_valid && advance;
  assign rx.ready = !in_valid || advance;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_value <= HEAD_RESET;
      tail_value <= TAIL_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_HEAD: head_value <= cfg.data;
        REG_TAIL: tail_value <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  htlfc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .rx_byte    (in_byte),
    .head_value (head_value),
    .tail_value (tail_value),
    .res        (core_res),
    .stat       (core_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid && core_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind            <= core_res.kind;
      out_payload_byte    <= core_res.payload_byte;
      out_payload_count   <= core_res.payload_count;
      out_declared_length <= core_res.declared_length;
    end
  end

  assign res.valid           = out_valid;
  assign res.kind            = out_kind;
  assign res.payload_byte    = out_payload_byte;
  assign res.payload_count   = out_payload_count;
  assign res.declared_length = out_declared_length;

  // a result is only ever produced from inside an open frame
  a_res_in_frame: assert property (@(posedge clk) disable iff (rst)
    core_res.valid |-> core_stat.in_frame)
    else $error("result outside frame");

  // a tail result closes the frame
  a_tail_closes: assert property (@(posedge clk) disable iff (rst)
    (step && core_res.valid && (core_res.kind == KIND_GOOD || core_res.kind == KIND_BAD))
    |=> !core_stat.in_frame)
    else $error("frame still open after tail");

  // good frames have a nonzero count matching the length byte
  a_good_match: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == KIND_GOOD)
    |-> (out_payload_count == out_declared_length && out_payload_count != '0))
    else $error("good frame with mismatched count");

  // payload byte is zero on frame status results
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind != KIND_PAYLOAD) |-> (out_payload_byte == '0))
    else $error("nonzero payload byte on status result");

endmodule

// ===== tb/head_tail_length_frame_checker_unit_tb.sv =====
`timescale 1ns / 1ps

module head_tail_length_frame_checker_unit_tb;
  import htlfc_pkg::*;

  // One expected result beat: what the frame tracker says the block must emit.
  typedef struct {
    kind_t      kind;
    logic [7:0] pbyte;
    logic [7:0] count;
    logic [7:0] length;
  } frame_event_t;

  // Frame tracker plus checker. It keeps its own copy of the head/tail
  // settings and of the open-frame state, turns every accepted rx beat into
  // zero or one expected result, and checks result beats in order.
  class frame_scoreboard;
    logic [7:0]   head_byte;
    logic [7:0]   tail_byte;
    bit           in_frm;
    bit           len_taken;
    logic [7:0]   len_byte;
    logic [7:0]   pay_count;
    frame_event_t expected_q[$];
    int           errors;
    int           bytes_noted;
    int           kind_seen[4];

    function new();
      head_byte = HEAD_RESET;
      tail_byte = TAIL_RESET;
      restart();
      in_frm    = 1'b0;
    endfunction

    function void restart();
      in_frm    = 1'b1;
      len_taken = 1'b0;
      len_byte  = '0;
      pay_count = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      if (idx == REG_HEAD) head_byte = val;
      else if (idx == REG_TAIL) tail_byte = val;
    endfunction

    function void push_event(kind_t k, logic [7:0] pb);
      frame_event_t ev;
      ev.kind   = k;
      ev.pbyte  = pb;
      ev.count  = pay_count;
      ev.length = len_byte;
      expected_q.push_back(ev);
    endfunction

    // Head wins over tail, tail over the length slot, length over payload.
    function void note_byte(logic [7:0] b);
      bytes_noted++;
      if (!in_frm) begin
        if (b == head_byte) restart();
      end else if (b == head_byte) begin
        push_event(KIND_ABORT, 8'h00);
        restart();
      end else if (b == tail_byte) begin
        push_event((len_taken && pay_count != 0 && pay_count == len_byte) ?
                   KIND_GOOD : KIND_BAD, 8'h00);
        restart();
        in_frm = 1'b0;
      end else if (!len_taken) begin
        len_byte  = b;
        len_taken = 1'b1;
      end else begin
        if (pay_count != COUNT_MAX) pay_count++;
        push_event(KIND_PAYLOAD, b);
      end
    endfunction

    function void check_result(logic [1:0] k, logic [7:0] pb, logic [7:0] cnt,
                               logic [7:0] len);
      frame_event_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result beat: kind %0d byte %02h count %0d length %0d",
                   k, pb, cnt, len);
        return;
      end
      want = expected_q.pop_front();
      if (k !== want.kind || pb !== want.pbyte || cnt !== want.count ||
          len !== want.length) begin
        errors++;
        if (errors <= 10)
          $display({"result mismatch: expected kind %0d byte %02h count %0d length %0d,",
                    " got kind %0d byte %02h count %0d length %0d"},
                   want.kind, want.pbyte, want.count, want.length, k, pb, cnt, len);
      end
      kind_seen[want.kind]++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  localparam int HOLD_CYCLES = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;

  htlfc_byte_if rx_if ();
  htlfc_res_if  res_if ();
  htlfc_cfg_if  cfg_if ();

  head_tail_length_frame_checker_unit dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  frame_scoreboard sb = new();

  int         burst_left = 0;
  int         bytes_sent = 0;
  int         settings   = 1;
  logic [7:0] cur_head   = HEAD_RESET;
  logic [7:0] cur_tail   = TAIL_RESET;
  bit         long_hold  = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Everything is sampled at the rising edge; all drivers use nonblocking
  // updates, so the values seen here are the ones the block saw at the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.index, cfg_if.data);
      if (rx_if.valid && rx_if.ready) sb.note_byte(rx_if.rx_byte);
      if (res_if.valid && res_if.ready)
        sb.check_result(res_if.kind, res_if.payload_byte, res_if.payload_count,
                        res_if.declared_length);
    end
  end

  // Result sink pacing: stretches of always-ready, coin-flip, sparse and
  // alternating ready. On request it holds ready low for a long counted
  // stretch so the block backs up and drops rx.ready.
  initial begin : sink_pacing
    int mode;
    int left;
    mode = 0;
    left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(10, 80);
        end
        left--;
        case (mode)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= 1'($urandom_range(0, 1));
          2: res_if.ready <= ($urandom_range(0, 3) == 0);
          default: res_if.ready <= ~res_if.ready;
        endcase
      end
    end
  end

  // One rx beat. The sender runs in bursts; between bursts it may go idle, or with
  // a zero gap keep valid high straight into the next burst.
  task automatic feed_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        rx_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
    bytes_sent++;
  endtask

  // Stop sending, let every expected result drain, then wait on so that beats
  // that make no result (length bytes, noise) also clear the pipeline.
  task automatic wait_idle();
    rx_if.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Both registers back to back on one held valid.
  task automatic set_config(input logic [7:0] h, input logic [7:0] t);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= REG_HEAD;
    cfg_if.data  <= h;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.index <= REG_TAIL;
    cfg_if.data  <= t;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    cur_head = h;
    cur_tail = t;
    settings++;
  endtask

  // A byte that is neither head nor tail under the current setting.
  function automatic logic [7:0] pick_plain();
    logic [7:0] v;
    v = 8'($urandom);
    while (v == cur_head || v == cur_tail) v = 8'($urandom);
    return v;
  endfunction

  task automatic long_frame(input int n, input logic [7:0] len);
    feed_byte(cur_head);
    feed_byte(len);
    for (int i = 0; i < n; i++) feed_byte(pick_plain());
    feed_byte(cur_tail);
  endtask

  // Mostly well-formed frames with random content; the rest is noise between
  // frames, frames cut short by a new head or an early tail, and raw bytes.
  task automatic random_frame();
    int         style;
    int         n;
    logic [7:0] len;
    style = $urandom_range(0, 99);
    if (style < 70) begin
      n   = $urandom_range(0, 12);
      // mostly a matching length byte, sometimes any value (bad frames, and
      // length bytes that collide with head or tail)
      len = ($urandom_range(0, 4) != 0) ? 8'(n) : 8'($urandom);
      long_frame(n, len);
    end else if (style < 80) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) feed_byte(8'($urandom));
    end else if (style < 92) begin
      feed_byte(cur_head);
      if ($urandom_range(0, 3) != 0) begin
        n = $urandom_range(0, 6);
        feed_byte(8'($urandom_range(0, 12)));
        for (int i = 0; i < n; i++) feed_byte(pick_plain());
      end
      // cut short: a new head aborts, a tail closes early
      feed_byte($urandom_range(0, 1) ? cur_head : cur_tail);
    end else begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 5))
          0: feed_byte(cur_head);
          1: feed_byte(cur_tail);
          default: feed_byte(8'($urandom));
        endcase
      end
    end
  endtask

  task automatic random_phase(input int count);
    int stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) random_frame();
  endtask

  initial begin : stimulus
    logic [7:0] opening[$];
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= '0;
    cfg_if.data   <= '0;
    rst           <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed beats on the reset setting: bytes outside a frame, a good
    // frame with extreme payload values, a length mismatch, tail before the
    // length byte, zero length with no payload, an abort followed by a
    // restarted good frame, and a length slot that holds the head byte.
    opening = '{8'h00, TAIL_RESET,
                HEAD_RESET, 8'h03, 8'h00, 8'h7F, 8'h80, TAIL_RESET,
                HEAD_RESET, 8'h05, 8'h11, TAIL_RESET,
                HEAD_RESET, TAIL_RESET,
                HEAD_RESET, 8'h00, TAIL_RESET,
                HEAD_RESET, 8'h02, 8'hAA, HEAD_RESET, 8'h01, 8'h55, TAIL_RESET,
                HEAD_RESET, HEAD_RESET, TAIL_RESET};
    foreach (opening[i]) feed_byte(opening[i]);

    // Saturating frame: 258 payload beats against length 255 must close
    // good. The sink holds off meanwhile so the block fills and stalls rx.
    wait_idle();
    long_hold = 1'b1;
    long_frame(258, COUNT_MAX);

    random_phase(170);
    set_config(8'h00, 8'hFF);
    random_phase(170);
    set_config(8'hFF, 8'h00);
    random_phase(170);
    // head equal to tail: inside a frame that byte only aborts and restarts
    set_config(8'h55, 8'h55);
    random_phase(170);
    set_config(8'($urandom), 8'($urandom));
    random_phase(170);

    wait_idle();
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.errors += sb.pending();
      $display("%0d expected result beats never arrived", sb.pending());
    end

    $display("run covered %0d rx beats over %0d head/tail settings, with a %0d-cycle sink hold",
             sb.bytes_noted, settings, HOLD_CYCLES);
    $display("result beats checked: payload %0d, good %0d, bad %0d, aborted %0d",
             sb.kind_seen[KIND_PAYLOAD], sb.kind_seen[KIND_GOOD], sb.kind_seen[KIND_BAD],
             sb.kind_seen[KIND_ABORT]);
    if (sb.errors == 0) begin
      $display("head_tail_length_frame_checker_unit verification clean");
    end else begin
      $display("head_tail_length_frame_checker_unit verification failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("timeout with %0d result beats outstanding", sb.pending());
    $display("head_tail_length_frame_checker_unit verification failed");
    $finish;
  end

endmodule
